FILE: sv/mfb_pkg.sv
// Package with the shared types and constants of the monochrome frame buffer.
package mfb_pkg;

    // Operation codes carried in the operation field of an input transfer.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Number of output transfers per read out, minus one.
    localparam logic [1:0] LAST_BEAT = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT_RD0,
        ST_PLOT_WR0,
        ST_PLOT_RD1,
        ST_PLOT_WR1,
        ST_READ_RD,
        ST_READ_LD,
        ST_READ_OUT
    } t_state;

    // Source of the store address for a read or write.
    typedef enum logic [1:0] {
        SEL_CLR,
        SEL_B0,
        SEL_B1,
        SEL_IDX
    } t_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic mem_rd;
        logic mem_wr;
        t_sel sel;
        logic clr_step;
        logic out_load;
        logic out_valid;
        logic out_next;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic has_m0;
        logic has_m1;
        logic last_beat;
    } t_stat;

endpackage

FILE: sv/mfb_if.sv
// Valid/ready channel interfaces for the frame buffer's input and output transfers.
interface mfb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] pattern;
    logic [3:0] count;
    logic [9:0] index;

    modport source (output valid, output operation, output x, output y, output pattern,
                    output count, output index, input ready);
    modport sink (input valid, input operation, input x, input y, input pattern,
                  input count, input index, output ready);
endinterface

interface mfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

FILE: sv/mfb_ctrl.sv
// Controller state machine that sequences clear, plot and read-out operations.
module mfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  logic          i_out_ready,
    input  mfb_pkg::t_stat i_stat,
    output mfb_pkg::t_cmd  o_cmd
);

    mfb_pkg::t_state r_state;
    mfb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = mfb_pkg::SEL_CLR;
        case (r_state)
            mfb_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.sel      = mfb_pkg::SEL_CLR;
                if (i_stat.clr_done) begin
                    n_state = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    case (i_op)
                        mfb_pkg::OP_CLEAR: n_state = mfb_pkg::ST_CLEAR;
                        mfb_pkg::OP_PLOT:  n_state = mfb_pkg::ST_PLOT_RD0;
                        mfb_pkg::OP_READ:  n_state = mfb_pkg::ST_READ_RD;
                        default:           n_state = mfb_pkg::ST_IDLE;
                    endcase
                end
            end
            mfb_pkg::ST_PLOT_RD0: begin
                o_cmd.mem_rd = i_stat.has_m0;
                o_cmd.sel    = mfb_pkg::SEL_B0;
                n_state      = mfb_pkg::ST_PLOT_WR0;
            end
            mfb_pkg::ST_PLOT_WR0: begin
                o_cmd.mem_wr = i_stat.has_m0;
                o_cmd.sel    = mfb_pkg::SEL_B0;
                n_state      = mfb_pkg::ST_PLOT_RD1;
            end
            mfb_pkg::ST_PLOT_RD1: begin
                o_cmd.mem_rd = i_stat.has_m1;
                o_cmd.sel    = mfb_pkg::SEL_B1;
                n_state      = mfb_pkg::ST_PLOT_WR1;
            end
            mfb_pkg::ST_PLOT_WR1: begin
                o_cmd.mem_wr = i_stat.has_m1;
                o_cmd.sel    = mfb_pkg::SEL_B1;
                n_state      = mfb_pkg::ST_IDLE;
            end
            mfb_pkg::ST_READ_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.sel    = mfb_pkg::SEL_IDX;
                n_state      = mfb_pkg::ST_READ_LD;
            end
            mfb_pkg::ST_READ_LD: begin
                // The registered read data is valid now and moves into the output register.
                o_cmd.out_load = 1'b1;
                n_state        = mfb_pkg::ST_READ_OUT;
            end
            mfb_pkg::ST_READ_OUT: begin
                o_cmd.out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    if (i_stat.last_beat) begin
                        n_state = mfb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mfb_datapath.sv
// Datapath with the frame store, plot masks, clear sweep and gray read-out register.
module mfb_datapath #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_x,
    input  logic [7:0]     i_y,
    input  logic [7:0]     i_pattern,
    input  logic [3:0]     i_count,
    input  logic [9:0]     i_index,
    input  mfb_pkg::t_cmd  i_cmd,
    output mfb_pkg::t_stat o_stat,
    output logic [7:0]     o_data_byte,
    output logic           o_last
);

    localparam int ROW_BYTES   = (WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [7:0]        r_store [STORE_BYTES];
    logic [7:0]        r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr0;
    logic [ADDR_W-1:0] r_addr1;
    logic [ADDR_W-1:0] r_idx;
    logic              r_idx_ok;
    logic [7:0]        r_mask0;
    logic [7:0]        r_mask1;
    logic [7:0]        r_byte;
    logic [1:0]        r_beat;

    logic [7:0]        n_mask0;
    logic [7:0]        n_mask1;
    logic [31:0]       n_row_base;
    logic [4:0]        n_byte1;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        wr_data;
    logic              rd_en;

    // Pattern pixel k lands at column x + k, wrapping at 256; it falls into
    // the byte of x or the next byte, so two masks cover every pattern.
    always_comb begin
        logic [7:0] col;
        logic       on;
        n_mask0 = '0;
        n_mask1 = '0;
        for (int k = 0; k < 8; k++) begin
            col = i_x + 8'(k);
            on  = i_pattern[7 - k] && (32'(i_count) > k) &&
                  ({1'b0, col} < 9'(WIDTH)) && ({1'b0, i_y} < 9'(HEIGHT));
            if (on) begin
                if (col[7:3] == i_x[7:3]) begin
                    n_mask0[col[2:0]] = 1'b1;
                end else begin
                    n_mask1[col[2:0]] = 1'b1;
                end
            end
        end
        n_row_base = 32'(i_y) * 32'(ROW_BYTES);
        n_byte1    = i_x[7:3] + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mask0  <= n_mask0;
            r_mask1  <= n_mask1;
            r_addr0  <= ADDR_W'(n_row_base + 32'(i_x[7:3]));
            r_addr1  <= ADDR_W'(n_row_base + 32'(n_byte1));
            r_idx    <= ADDR_W'(i_index);
            r_idx_ok <= (32'(i_index) < 32'(STORE_BYTES));
        end
    end

    always_comb begin
        case (i_cmd.sel)
            mfb_pkg::SEL_CLR: begin
                mem_addr = r_clr_addr;
                wr_data  = '0;
            end
            mfb_pkg::SEL_B0: begin
                mem_addr = r_addr0;
                wr_data  = r_rdata | r_mask0;
            end
            mfb_pkg::SEL_B1: begin
                mem_addr = r_addr1;
                wr_data  = r_rdata | r_mask1;
            end
            mfb_pkg::SEL_IDX: begin
                mem_addr = r_idx;
                wr_data  = r_rdata;
            end
            default: begin
                mem_addr = r_clr_addr;
                wr_data  = '0;
            end
        endcase
        rd_en = i_cmd.mem_rd && ((i_cmd.sel != mfb_pkg::SEL_IDX) || r_idx_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_store[mem_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_store[mem_addr];
        end
    end

    // Clear sweep address returns to zero at the end of each pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            if (o_stat.clr_done) begin
                r_clr_addr <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Read-out register: shifts one bit pair per output transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_byte <= r_idx_ok ? r_rdata : 8'd0;
            r_beat <= '0;
        end else if (i_cmd.out_next) begin
            r_byte <= {2'b00, r_byte[7:2]};
            r_beat <= r_beat + 2'd1;
        end
    end

    assign o_data_byte      = {{4{r_byte[1]}}, {4{r_byte[0]}}};
    assign o_last           = (r_beat == mfb_pkg::LAST_BEAT);
    assign o_stat.clr_done  = (r_clr_addr == ADDR_W'(STORE_BYTES - 1));
    assign o_stat.has_m0    = (r_mask0 != '0);
    assign o_stat.has_m1    = (r_mask1 != '0);
    assign o_stat.last_beat = (r_beat == mfb_pkg::LAST_BEAT);

`ifndef NO_ASSERTIONS
    a_wr0_after_rd0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_wr && i_cmd.sel == mfb_pkg::SEL_B0) |->
        $past(i_cmd.mem_rd && i_cmd.sel == mfb_pkg::SEL_B0))
        else $error("plot write of first byte without its read");
    a_wr1_after_rd1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_wr && i_cmd.sel == mfb_pkg::SEL_B1) |->
        $past(i_cmd.mem_rd && i_cmd.sel == mfb_pkg::SEL_B1))
        else $error("plot write of second byte without its read");
    a_wr_has_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_wr && i_cmd.sel == mfb_pkg::SEL_B0) |-> (r_mask0 != '0))
        else $error("plot write with an empty mask");
    a_sweep_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_cmd.clr_step) |-> (r_clr_addr == '0))
        else $error("clear sweep does not start at address zero");
    a_no_accept_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_valid |-> !i_cmd.in_ready)
        else $error("input accepted while a read out is pending");
`endif

endmodule

FILE: sv/mono_framebuffer_plot_gray_expand_core.sv
// Top level of the 1-bit frame buffer with plot and 4-bit gray read-out.
//
//   Channel  Dir  Payload                                   Transfer
//   i_in     in   operation, x, y, pattern, count, index    valid & ready
//   o_out    out  data_byte, last                           valid & ready
//
// Plot goes through the transfer, then a read and a write-back for each of the
// two store bytes a pattern can touch, in turn on the single store port.
// Read out goes through the transfer, the store read and the load of the output
// register, then gives four output transfers, one per cycle while the receiver is
// ready, the last with last set.
// Clear writes one store byte per cycle across all ROW_BYTES * HEIGHT bytes
// (1024 at default sizes); the same sweep runs after reset, and no input
// transfer is taken during it. A stalled output holds its byte and the block
// takes no new input until the fourth byte has been transferred.
module mono_framebuffer_plot_gray_expand_core #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfb_in_if.sink    i_in,
    mfb_out_if.source o_out
);

    mfb_pkg::t_cmd  cmd;
    mfb_pkg::t_stat stat;

    // The controller owns the handshake; the datapath owns store and payload.
    mfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.operation),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mfb_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_x         (i_in.x),
        .i_y         (i_in.y),
        .i_pattern   (i_in.pattern),
        .i_count     (i_in.count),
        .i_index     (i_in.index),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data_byte (o_out.data_byte),
        .o_last      (o_out.last)
    );

    assign i_in.ready  = cmd.in_ready;
    assign o_out.valid = cmd.out_valid;

endmodule

FILE: verif/mono_framebuffer_plot_gray_expand_core_test.sv
// Self-checking testbench for the 1-bit frame buffer with plot and gray read-out.
`timescale 1ns / 1ps

module mono_framebuffer_plot_gray_expand_core_test;

    // Screen size used for this run; it matches the block's defaults.
    localparam int WIDTH       = 128;
    localparam int HEIGHT      = 64;
    localparam int ROW_BYTES   = (WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT;

    // The block has no name for the fourth operation code; it must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A long receiver hold-off, long enough to back the block up into its input.
    localparam int LONG_HOLD = 300;

    // One input transfer as the sender builds it.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] pattern;
        logic [3:0] count;
        logic [9:0] index;
    } t_fb_cmd;

    // One expected output transfer of a read out.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_gray_beat;

    logic i_clk;
    logic i_rst_n;

    mfb_in_if  in_ch ();
    mfb_out_if out_ch ();

    mono_framebuffer_plot_gray_expand_core #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Our own copy of the frame store, updated as each input transfer is taken.
    logic [7:0] frame_model [STORE_BYTES];

    // Gray bytes that the block still owes us, oldest first.
    t_gray_beat pending_beats [$];
    t_gray_beat front_beat;

    int err_count;
    int n_plots;
    int n_reads;
    int n_clears;
    int n_ignored;
    int n_beats;

    // When set, the sender offers items back to back and the receiver never stalls.
    bit tx_steady;
    bit rx_steady;

    // A hold-off request for the receiver, picked up at its next falling edge.
    int long_hold_req;
    int rx_stall_left;

    // Byte address of the most recent on-screen plot, so that reads hit live data.
    int recent_addr;

    // The clock: 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A generous upper bound on the whole run, several times the slowest
    // correct run even with every stall at its longest.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int expected, input int got);
        err_count++;
        $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, expected, got);
    endtask

    // Random idle length: mostly none, sometimes a few cycles, now and then a long gap.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Updates the model store for one accepted transfer and queues the gray bytes
    // that a read out must produce.
    task automatic update_frame_model(input t_fb_cmd c);
        int         k;
        int         n_pix;
        int         addr;
        logic [7:0] col;
        logic [7:0] src;
        logic [1:0] pair;
        t_gray_beat beat;
        case (c.op)
            mfb_pkg::OP_CLEAR: begin
                foreach (frame_model[i]) begin
                    frame_model[i] = 8'h00;
                end
                n_clears++;
            end
            mfb_pkg::OP_PLOT: begin
                // A count above eight uses the whole pattern byte.
                n_pix = (c.count > 4'd8) ? 8 : int'(c.count);
                for (k = 0; k < n_pix; k++) begin
                    // The column sum wraps in eight bits before the bound check.
                    col = c.x + 8'(k);
                    if (c.pattern[7 - k] && col < WIDTH && c.y < HEIGHT) begin
                        addr = int'(c.y) * ROW_BYTES + int'(col >> 3);
                        frame_model[addr][col[2:0]] = 1'b1;
                    end
                end
                n_plots++;
            end
            mfb_pkg::OP_READ: begin
                src = (c.index < STORE_BYTES) ? frame_model[c.index] : 8'h00;
                for (k = 0; k < 4; k++) begin
                    pair           = src[2 * k +: 2];
                    beat.data_byte = {pair[1] ? 4'hF : 4'h0, pair[0] ? 4'hF : 4'h0};
                    beat.last      = (k == int'(mfb_pkg::LAST_BEAT));
                    pending_beats.push_back(beat);
                end
                n_reads++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // Offers one item after a random gap and holds it until the block takes it.
    task automatic send_item(input t_fb_cmd c);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= c.op;
        in_ch.x         <= c.x;
        in_ch.y         <= c.y;
        in_ch.pattern   <= c.pattern;
        in_ch.count     <= c.count;
        in_ch.index     <= c.index;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        update_frame_model(c);
    endtask

    // Builders that fill the fields an operation does not use with noise.
    function automatic t_fb_cmd mk_plot(input logic [7:0] px, input logic [7:0] py,
                                        input logic [7:0] pat, input logic [3:0] cnt);
        t_fb_cmd c;
        c.op      = mfb_pkg::OP_PLOT;
        c.x       = px;
        c.y       = py;
        c.pattern = pat;
        c.count   = cnt;
        c.index   = 10'($urandom);
        return c;
    endfunction

    function automatic t_fb_cmd mk_read(input int idx);
        t_fb_cmd c;
        c.op      = mfb_pkg::OP_READ;
        c.x       = 8'($urandom);
        c.y       = 8'($urandom);
        c.pattern = 8'($urandom);
        c.count   = 4'($urandom);
        c.index   = 10'(idx);
        return c;
    endfunction

    function automatic t_fb_cmd mk_other(input logic [1:0] op);
        t_fb_cmd c;
        c       = t_fb_cmd'($bits(t_fb_cmd)'({$urandom, $urandom}));
        c.op    = op;
        return c;
    endfunction

    // Receiver: ready drops for random stretches, or for one long hold-off on
    // request. Each falling edge makes exactly one assignment to ready.
    initial begin
        out_ch.ready  = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req > 0) begin
                rx_stall_left = long_hold_req;
                long_hold_req = 0;
            end
            if (rx_stall_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 9) == 0) begin
                    rx_stall_left = idle_len();
                end
            end
        end
    end

    // Checker: every output transfer is compared with the oldest expected byte.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("output transfer with nothing expected", 0,
                                {out_ch.data_byte, out_ch.last});
            end else begin
                front_beat = pending_beats.pop_front();
                n_beats++;
                if (out_ch.data_byte !== front_beat.data_byte) begin
                    report_mismatch("data_byte", front_beat.data_byte, out_ch.data_byte);
                end
                if (out_ch.last !== front_beat.last) begin
                    report_mismatch("last", front_beat.last, out_ch.last);
                end
            end
        end
    end

    // The store must come out of reset all zero.
    task automatic test_reset_contents();
        send_item(mk_read(0));
        send_item(mk_read(STORE_BYTES - 1));
        send_item(mk_read($urandom_range(0, STORE_BYTES - 1)));
    endtask

    // Screen corners, edges, column wrap, off-screen rows, odd counts, the ignored code
    // and a clear, each read back through the gray expansion.
    task automatic test_plot_edges();
        send_item(mk_plot(8'd0, 8'd0, 8'hFF, 4'd8));
        send_item(mk_read(0));
        send_item(mk_plot(8'd127, 8'd63, 8'h80, 4'd1));
        send_item(mk_read(63 * ROW_BYTES + 15));
        // Half of this pattern runs off the right edge and is dropped.
        send_item(mk_plot(8'd124, 8'd10, 8'hFF, 4'd8));
        send_item(mk_read(10 * ROW_BYTES + 15));
        // This one wraps past column 255 back to the left edge.
        send_item(mk_plot(8'd252, 8'd20, 8'hFF, 4'd8));
        send_item(mk_read(20 * ROW_BYTES));
        // Rows below the screen are dropped entirely.
        send_item(mk_plot(8'd5, 8'd64, 8'hFF, 4'd8));
        send_item(mk_plot(8'd5, 8'd255, 8'hFF, 4'd15));
        send_item(mk_read(63 * ROW_BYTES));
        // A count of zero sets nothing; a count above eight acts as eight.
        send_item(mk_plot(8'd40, 8'd30, 8'hFF, 4'd0));
        send_item(mk_plot(8'd48, 8'd30, 8'hAA, 4'd15));
        send_item(mk_read(30 * ROW_BYTES + 5));
        send_item(mk_read(30 * ROW_BYTES + 6));
        // Straddles two store bytes.
        send_item(mk_plot(8'd3, 8'd31, 8'h55, 4'd8));
        send_item(mk_read(31 * ROW_BYTES));
        send_item(mk_read(31 * ROW_BYTES + 1));
        send_item(mk_other(OP_UNUSED));
        send_item(mk_read(31 * ROW_BYTES));
        send_item(mk_other(mfb_pkg::OP_CLEAR));
        send_item(mk_read(0));
    endtask

    // Random traffic: mostly on-screen plots followed by reads of the bytes they
    // touched, with some full-range noise, rare clears and the ignored code.
    task automatic test_random_traffic(input int n_items);
        int      done;
        int      r;
        t_fb_cmd c;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                c = mk_plot(($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, WIDTH - 1))
                                                       : 8'($urandom),
                            ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, HEIGHT - 1))
                                                         : 8'($urandom),
                            8'($urandom),
                            ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                                       : 4'($urandom));
                if (c.x < WIDTH && c.y < HEIGHT) begin
                    recent_addr = int'(c.y) * ROW_BYTES + int'(c.x >> 3);
                end
            end else if (r < 88) begin
                if ($urandom_range(0, 9) < 7) begin
                    c = mk_read(recent_addr + int'($urandom_range(0, 1)) < STORE_BYTES
                                ? recent_addr + int'($urandom_range(0, 1)) : recent_addr);
                end else begin
                    c = mk_read($urandom_range(0, 1023));
                end
            end else if (r < 92) begin
                c = mk_other(mfb_pkg::OP_CLEAR);
            end else if (r < 96) begin
                c = mk_other(OP_UNUSED);
            end else begin
                c = mk_other(2'($urandom_range(mfb_pkg::OP_CLEAR, mfb_pkg::OP_READ)));
            end
            send_item(c);
            if (c.op != OP_UNUSED) begin
                done++;
            end
        end
    endtask

    // The receiver stops for a long stretch while reads keep coming, so the
    // block has to stall its input until the output drains.
    task automatic test_output_backpressure();
        int k;
        tx_steady     = 1'b1;
        long_hold_req = LONG_HOLD;
        for (k = 0; k < 12; k++) begin
            send_item(mk_read($urandom_range(0, STORE_BYTES - 1)));
        end
        tx_steady = 1'b0;
    endtask

    // Back-to-back transfers with no stalls on either side.
    task automatic test_steady_stream();
        int k;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (k = 0; k < 30; k++) begin
            if (k % 2 == 0) begin
                send_item(mk_plot(8'($urandom_range(0, WIDTH - 1)),
                                  8'($urandom_range(0, HEIGHT - 1)),
                                  8'($urandom), 4'($urandom_range(1, 8))));
            end else begin
                send_item(mk_read($urandom_range(0, STORE_BYTES - 1)));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = mfb_pkg::OP_CLEAR;
        in_ch.x         = 8'd0;
        in_ch.y         = 8'd0;
        in_ch.pattern   = 8'd0;
        in_ch.count     = 4'd0;
        in_ch.index     = 10'd0;
        err_count       = 0;
        n_plots         = 0;
        n_reads         = 0;
        n_clears        = 0;
        n_ignored       = 0;
        n_beats         = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        long_hold_req   = 0;
        recent_addr     = 0;
        foreach (frame_model[i]) begin
            frame_model[i] = 8'h00;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its store after reset; send_item simply waits on ready.
        test_reset_contents();
        test_plot_edges();
        test_output_backpressure();
        test_steady_stream();
        test_random_traffic(195);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        // A trailing clear may still be sweeping; give stray outputs time to show.
        repeat (STORE_BYTES + 100) @(posedge i_clk);

        $display("covered %0d plots, %0d read outs, %0d clears, %0d ignored codes",
                 n_plots, n_reads, n_clears, n_ignored);
        $display("%0d gray bytes compared, one receiver hold-off of %0d cycles",
                 n_beats, LONG_HOLD);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/mfb_pkg.sv
sv/mfb_if.sv
sv/mfb_ctrl.sv
sv/mfb_datapath.sv
sv/mono_framebuffer_plot_gray_expand_core.sv
verif/mono_framebuffer_plot_gray_expand_core_test.sv
